/* rtl/multi_pattern_match_counter_macros.svh */
// Assertion macros shared by the RTL of the multi-pattern match counter.
`ifndef MULTI_PATTERN_MATCH_COUNTER_MACROS_SVH
`define MULTI_PATTERN_MATCH_COUNTER_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define MPMC_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check that post holds in the cycle after pre.
`define MPMC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/mpmc_pkg.sv */
// Package of the multi-pattern match counter: constants, payload and control types.
package mpmc_pkg;

   localparam int MAX_NODES_DEF = 4096;
   localparam int ALPHABET_DEF  = 26;
   localparam int SYM_W         = 5;
   localparam int COUNT_W       = 16;

   typedef enum logic [1:0] {
      OP_PAT_LETTER = 2'd0,
      OP_PAT_END    = 2'd1,
      OP_BUILD      = 2'd2,
      OP_TEXT       = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [SYM_W-1:0] symbol;
      logic             last_of_text;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] match_count;
      logic               table_full;
   } rsp_type;

   // per-field write enables of the node memory
   typedef struct packed {
      logic fail;
      logic parent;
      logic letter;
      logic count;
      logic visited;
      logic queue;
   } node_we_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_PAT,
      S_END,
      S_B_POP,
      S_B_K,
      S_B_P,
      S_B_F,
      S_B_G,
      S_B_LET,
      S_B_CHILD,
      S_B_FILL,
      S_T_GOTO,
      S_T_CHK,
      S_FIN
   } state_type;

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
   endfunction

endpackage

/* rtl/mpmc_goto_mem.sv */
// Transition table memory: one write port, one registered read port.
module mpmc_goto_mem #(
   parameter int AW = 17,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mpmc_node_mem.sv */
// Per-node memory: failure link, parent, letter, pattern count, visit mark, BFS queue.
module mpmc_node_mem #(
   parameter int MaxNodes = mpmc_pkg::MAX_NODES_DEF,
   parameter int NW       = $clog2(MaxNodes)
) (
   input  logic                         clock,
   input  logic [NW-1:0]                rd_addr,
   output logic [NW-1:0]                rd_fail,
   output logic [NW-1:0]                rd_parent,
   output logic [mpmc_pkg::SYM_W-1:0]   rd_letter,
   output logic [mpmc_pkg::COUNT_W-1:0] rd_count,
   output logic                         rd_visited,
   output logic [NW-1:0]                rd_queue,
   input  mpmc_pkg::node_we_type        wr_en,
   input  logic [NW-1:0]                wr_addr,
   input  logic [NW-1:0]                wr_fail,
   input  logic [NW-1:0]                wr_parent,
   input  logic [mpmc_pkg::SYM_W-1:0]   wr_letter,
   input  logic [mpmc_pkg::COUNT_W-1:0] wr_count,
   input  logic                         wr_visited,
   input  logic [NW-1:0]                wr_queue
);

   logic [NW-1:0]                fail_mem    [MaxNodes];
   logic [NW-1:0]                parent_mem  [MaxNodes];
   logic [mpmc_pkg::SYM_W-1:0]   letter_mem  [MaxNodes];
   logic [mpmc_pkg::COUNT_W-1:0] count_mem   [MaxNodes];
   logic                         visited_mem [MaxNodes];
   logic [NW-1:0]                queue_mem   [MaxNodes];

   logic [NW-1:0]                fail_ff;
   logic [NW-1:0]                parent_ff;
   logic [mpmc_pkg::SYM_W-1:0]   letter_ff;
   logic [mpmc_pkg::COUNT_W-1:0] count_ff;
   logic                         visited_ff;
   logic [NW-1:0]                queue_ff;

   always_ff @(posedge clock) begin
      if (wr_en.fail)    fail_mem[wr_addr]    <= wr_fail;
      if (wr_en.parent)  parent_mem[wr_addr]  <= wr_parent;
      if (wr_en.letter)  letter_mem[wr_addr]  <= wr_letter;
      if (wr_en.count)   count_mem[wr_addr]   <= wr_count;
      if (wr_en.visited) visited_mem[wr_addr] <= wr_visited;
      if (wr_en.queue)   queue_mem[wr_addr]   <= wr_queue;
      fail_ff    <= fail_mem[rd_addr];
      parent_ff  <= parent_mem[rd_addr];
      letter_ff  <= letter_mem[rd_addr];
      count_ff   <= count_mem[rd_addr];
      visited_ff <= visited_mem[rd_addr];
      queue_ff   <= queue_mem[rd_addr];
   end

   assign rd_fail    = fail_ff;
   assign rd_parent  = parent_ff;
   assign rd_letter  = letter_ff;
   assign rd_count   = count_ff;
   assign rd_visited = visited_ff;
   assign rd_queue   = queue_ff;

endmodule

/* rtl/multi_pattern_match_counter.sv */
// Top level of the multi-pattern match counter (Aho-Corasick automaton).
//
// Usage: send transactions on the req_ channel. Pattern letters (opcode 0) and
// end-of-pattern marks (opcode 1) grow a trie; one build command (opcode 2)
// turns it into a full automaton; text letters (opcode 3) step it. A text
// letter with last_of_text set returns one rsp_ transaction: the number of
// dictionary patterns seen (saturating at 65535) and the table-full flag.
// Steps: a pattern letter or end mark does one read and at most one write-back
// of the transition or node memory; an ignored transaction is simply taken. A text
// letter reads the transition memory (not when out of range), then checks each node
// on its failure chain (each newly visited node and the visited node that stops the
// walk), and a letter that ends the text also passes through S_FIN.
// The build walks every node once in BFS order: pop, failure link (not for the
// root), then a read of each letter of its row and a fill of each missing edge,
// in turn through the single transition port.
// After reset the block sweeps both memories once with req_ready low, then idles.
// The result sits in an output register: new requests are taken while it
// waits, and only an end of text stalls while a previous result is unread.
// A new dictionary needs a reset.
`include "multi_pattern_match_counter_macros.svh"

module multi_pattern_match_counter #(
   parameter int MaxNodes = mpmc_pkg::MAX_NODES_DEF,
   parameter int Alphabet = mpmc_pkg::ALPHABET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpmc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mpmc_pkg::rsp_type rsp_data
);

   localparam int SW      = mpmc_pkg::SYM_W;
   localparam int CW      = mpmc_pkg::COUNT_W;
   localparam int NW      = $clog2(MaxNodes);
   localparam int GW      = NW + SW;
   // letters at or above 2**SW can never be entered, so rows stop there
   localparam int Letters = (Alphabet < 2**SW) ? Alphabet : 2**SW;
   localparam logic [SW-1:0] LastLetter = SW'(Letters - 1);
   localparam logic [NW-1:0] Root       = NW'(1);
   localparam logic [NW-1:0] LastNode   = NW'(MaxNodes - 1);
   localparam logic [GW-1:0] ClearLast  = GW'(MaxNodes * (2**SW) - 1);

   mpmc_pkg::state_type state_ff, state_in;

   logic [GW-1:0] clr_ff, clr_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] next_free_ff, next_free_in;
   logic [CW-1:0] total_ff, total_in;
   logic          ovf_ff, ovf_in;
   logic          built_ff, built_in;
   logic [NW:0]   head_ff, head_in;
   logic [NW:0]   tail_ff, tail_in;
   logic [NW-1:0] k_ff, k_in;
   logic [NW-1:0] f_ff, f_in;
   logic [NW-1:0] u_ff, u_in;
   logic [SW-1:0] letter_ff, letter_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] sym_ff, sym_in;
   logic          last_ff, last_in;

   logic              rsp_valid_ff;
   mpmc_pkg::rsp_type rsp_data_ff;
   logic              load_rsp;
   logic              out_free;

   logic req_fire;
   logic sym_ok;
   logic [NW-1:0] new_node;

   // transition memory ports
   logic [GW-1:0] gt_rd_addr;
   logic [NW-1:0] gt_rd_data;
   logic          gt_we;
   logic [GW-1:0] gt_wr_addr;
   logic [NW-1:0] gt_wr_data;

   // node memory ports
   logic [NW-1:0]         nd_rd_addr;
   logic [NW-1:0]         nd_rd_fail;
   logic [NW-1:0]         nd_rd_parent;
   logic [SW-1:0]         nd_rd_letter;
   logic [CW-1:0]         nd_rd_count;
   logic                  nd_rd_visited;
   logic [NW-1:0]         nd_rd_queue;
   mpmc_pkg::node_we_type nd_we;
   logic [NW-1:0]         nd_wr_addr;
   logic [NW-1:0]         nd_wr_fail;
   logic [NW-1:0]         nd_wr_parent;
   logic [SW-1:0]         nd_wr_letter;
   logic [CW-1:0]         nd_wr_count;
   logic                  nd_wr_visited;
   logic [NW-1:0]         nd_wr_queue;

   mpmc_goto_mem #(
      .AW(GW),
      .DW(NW)
   ) u_goto_mem (
      .clock   (clock),
      .rd_addr (gt_rd_addr),
      .rd_data (gt_rd_data),
      .wr_en   (gt_we),
      .wr_addr (gt_wr_addr),
      .wr_data (gt_wr_data)
   );

   mpmc_node_mem #(
      .MaxNodes(MaxNodes),
      .NW      (NW)
   ) u_node_mem (
      .clock      (clock),
      .rd_addr    (nd_rd_addr),
      .rd_fail    (nd_rd_fail),
      .rd_parent  (nd_rd_parent),
      .rd_letter  (nd_rd_letter),
      .rd_count   (nd_rd_count),
      .rd_visited (nd_rd_visited),
      .rd_queue   (nd_rd_queue),
      .wr_en      (nd_we),
      .wr_addr    (nd_wr_addr),
      .wr_fail    (nd_wr_fail),
      .wr_parent  (nd_wr_parent),
      .wr_letter  (nd_wr_letter),
      .wr_count   (nd_wr_count),
      .wr_visited (nd_wr_visited),
      .wr_queue   (nd_wr_queue)
   );

   assign req_ready = (state_ff == mpmc_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign sym_ok    = (32'(req_data.symbol) < Alphabet);
   assign new_node  = next_free_ff + NW'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpmc_pkg::S_CLEAR: begin
            if (clr_ff == ClearLast) state_in = mpmc_pkg::S_IDLE;
         end
         mpmc_pkg::S_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  mpmc_pkg::OP_PAT_LETTER: begin
                     if (!built_ff && sym_ok) state_in = mpmc_pkg::S_PAT;
                  end
                  mpmc_pkg::OP_PAT_END: begin
                     if (!built_ff) state_in = mpmc_pkg::S_END;
                  end
                  mpmc_pkg::OP_BUILD: begin
                     if (!built_ff) state_in = mpmc_pkg::S_B_POP;
                  end
                  mpmc_pkg::OP_TEXT: begin
                     if (!built_ff) begin
                        if (req_data.last_of_text) state_in = mpmc_pkg::S_FIN;
                     end else if (sym_ok) begin
                        state_in = mpmc_pkg::S_T_GOTO;
                     end else begin
                        state_in = mpmc_pkg::S_T_CHK;
                     end
                  end
                  default: state_in = mpmc_pkg::S_IDLE;
               endcase
            end
         end
         mpmc_pkg::S_PAT, mpmc_pkg::S_END: state_in = mpmc_pkg::S_IDLE;
         mpmc_pkg::S_B_POP: state_in = mpmc_pkg::S_B_K;
         mpmc_pkg::S_B_K: begin
            state_in = (nd_rd_queue == Root) ? mpmc_pkg::S_B_LET : mpmc_pkg::S_B_P;
         end
         mpmc_pkg::S_B_P: state_in = mpmc_pkg::S_B_F;
         mpmc_pkg::S_B_F: state_in = mpmc_pkg::S_B_G;
         mpmc_pkg::S_B_G: state_in = mpmc_pkg::S_B_LET;
         mpmc_pkg::S_B_LET: state_in = mpmc_pkg::S_B_CHILD;
         mpmc_pkg::S_B_CHILD, mpmc_pkg::S_B_FILL: begin
            if (state_ff == mpmc_pkg::S_B_CHILD && gt_rd_data == '0) begin
               state_in = mpmc_pkg::S_B_FILL;
            end else if (idx_ff != LastLetter) begin
               state_in = mpmc_pkg::S_B_LET;
            end else if (head_ff < tail_in) begin
               state_in = mpmc_pkg::S_B_POP;
            end else begin
               state_in = mpmc_pkg::S_IDLE;
            end
         end
         mpmc_pkg::S_T_GOTO: begin
            if (gt_rd_data != '0) state_in = mpmc_pkg::S_T_CHK;
            else state_in = last_ff ? mpmc_pkg::S_FIN : mpmc_pkg::S_IDLE;
         end
         mpmc_pkg::S_T_CHK: begin
            if (!nd_rd_visited && nd_rd_fail != '0) state_in = mpmc_pkg::S_T_CHK;
            else state_in = last_ff ? mpmc_pkg::S_FIN : mpmc_pkg::S_IDLE;
         end
         mpmc_pkg::S_FIN: begin
            if (out_free) state_in = mpmc_pkg::S_IDLE;
         end
         default: state_in = mpmc_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      next_free_in = next_free_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      built_in     = built_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      k_in         = k_ff;
      f_in         = f_ff;
      u_in         = u_ff;
      letter_in    = letter_ff;
      idx_in       = idx_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      load_rsp     = 1'b0;

      gt_rd_addr = '0;
      gt_we      = 1'b0;
      gt_wr_addr = '0;
      gt_wr_data = '0;

      nd_rd_addr    = '0;
      nd_we         = '0;
      nd_wr_addr    = '0;
      nd_wr_fail    = '0;
      nd_wr_parent  = '0;
      nd_wr_letter  = '0;
      nd_wr_count   = '0;
      nd_wr_visited = 1'b0;
      nd_wr_queue   = '0;

      case (state_ff)
         mpmc_pkg::S_CLEAR: begin
            // sentinel row leads to the root, all else clears
            clr_in     = clr_ff + GW'(1);
            gt_we      = 1'b1;
            gt_wr_addr = clr_ff;
            gt_wr_data = (clr_ff[GW-1:SW] == '0) ? Root : '0;
            if (clr_ff[SW-1:0] == '0) begin
               nd_we.fail    = 1'b1;
               nd_we.parent  = 1'b1;
               nd_we.count   = 1'b1;
               nd_we.visited = 1'b1;
               nd_wr_addr    = clr_ff[GW-1:SW];
            end
         end
         mpmc_pkg::S_IDLE: begin
            if (req_fire) begin
               sym_in  = req_data.symbol;
               last_in = req_data.last_of_text;
               case (req_data.opcode)
                  mpmc_pkg::OP_PAT_LETTER: gt_rd_addr = {cur_ff, req_data.symbol};
                  mpmc_pkg::OP_PAT_END:    nd_rd_addr = cur_ff;
                  mpmc_pkg::OP_BUILD: begin
                     if (!built_ff) begin
                        nd_we.queue = 1'b1;
                        nd_wr_addr  = '0;
                        nd_wr_queue = Root;
                        head_in     = '0;
                        tail_in     = (NW+1)'(1);
                     end
                  end
                  mpmc_pkg::OP_TEXT: begin
                     if (built_ff) begin
                        if (sym_ok) begin
                           gt_rd_addr = {cur_ff, req_data.symbol};
                        end else begin
                           cur_in     = Root;
                           u_in       = Root;
                           nd_rd_addr = Root;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         mpmc_pkg::S_PAT: begin
            if (gt_rd_data != '0) begin
               cur_in = gt_rd_data;
            end else if (next_free_ff >= LastNode) begin
               ovf_in = 1'b1;
            end else begin
               // allocate a node and hang it under the cursor
               gt_we         = 1'b1;
               gt_wr_addr    = {cur_ff, sym_ff};
               gt_wr_data    = new_node;
               nd_we.parent  = 1'b1;
               nd_we.letter  = 1'b1;
               nd_wr_addr    = new_node;
               nd_wr_parent  = cur_ff;
               nd_wr_letter  = sym_ff;
               cur_in        = new_node;
               next_free_in  = new_node;
            end
         end
         mpmc_pkg::S_END: begin
            nd_we.count = 1'b1;
            nd_wr_addr  = cur_ff;
            nd_wr_count = mpmc_pkg::sat_add(nd_rd_count, CW'(1));
            cur_in      = Root;
         end
         mpmc_pkg::S_B_POP: begin
            nd_rd_addr = head_ff[NW-1:0];
            head_in    = head_ff + (NW+1)'(1);
         end
         mpmc_pkg::S_B_K: begin
            k_in   = nd_rd_queue;
            idx_in = '0;
            if (nd_rd_queue == Root) begin
               f_in       = '0;
               nd_we.fail = 1'b1;
               nd_wr_addr = Root;
               nd_wr_fail = '0;
            end else begin
               nd_rd_addr = nd_rd_queue;
            end
         end
         mpmc_pkg::S_B_P: begin
            letter_in  = nd_rd_letter;
            nd_rd_addr = nd_rd_parent;
         end
         mpmc_pkg::S_B_F: begin
            gt_rd_addr = {nd_rd_fail, letter_ff};
         end
         mpmc_pkg::S_B_G: begin
            f_in       = gt_rd_data;
            nd_we.fail = 1'b1;
            nd_wr_addr = k_ff;
            nd_wr_fail = gt_rd_data;
            idx_in     = '0;
         end
         mpmc_pkg::S_B_LET: begin
            gt_rd_addr = {k_ff, idx_ff};
         end
         mpmc_pkg::S_B_CHILD, mpmc_pkg::S_B_FILL: begin
            if (state_ff == mpmc_pkg::S_B_CHILD && gt_rd_data == '0) begin
               // missing edge: fetch it from the failure node's row
               gt_rd_addr = {f_ff, idx_ff};
            end else begin
               if (state_ff == mpmc_pkg::S_B_CHILD) begin
                  if (tail_ff < (NW+1)'(MaxNodes)) begin
                     nd_we.queue = 1'b1;
                     nd_wr_addr  = tail_ff[NW-1:0];
                     nd_wr_queue = gt_rd_data;
                     tail_in     = tail_ff + (NW+1)'(1);
                  end
               end else begin
                  gt_we      = 1'b1;
                  gt_wr_addr = {k_ff, idx_ff};
                  gt_wr_data = gt_rd_data;
               end
               idx_in = idx_ff + SW'(1);
               if (idx_ff == LastLetter && !(head_ff < tail_in)) begin
                  built_in = 1'b1;
                  cur_in   = Root;
               end
            end
         end
         mpmc_pkg::S_T_GOTO: begin
            cur_in     = gt_rd_data;
            u_in       = gt_rd_data;
            nd_rd_addr = gt_rd_data;
         end
         mpmc_pkg::S_T_CHK: begin
            // count a node once, then advance along its failure link
            if (!nd_rd_visited) begin
               total_in      = mpmc_pkg::sat_add(total_ff, nd_rd_count);
               nd_we.visited = 1'b1;
               nd_wr_addr    = u_ff;
               nd_wr_visited = 1'b1;
               u_in          = nd_rd_fail;
               nd_rd_addr    = nd_rd_fail;
            end
         end
         mpmc_pkg::S_FIN: begin
            if (out_free) begin
               load_rsp = 1'b1;
               total_in = '0;
               cur_in   = Root;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpmc_pkg::S_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= Root;
         next_free_ff <= Root;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         built_ff     <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         next_free_ff <= next_free_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         built_ff     <= built_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      f_ff      <= f_in;
      u_ff      <= u_in;
      letter_ff <= letter_in;
      idx_ff    <= idx_in;
      sym_ff    <= sym_in;
      last_ff   <= last_in;
      if (load_rsp) begin
         rsp_data_ff.match_count <= total_ff;
         rsp_data_ff.table_full  <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MPMC_ASSERT_NEXT(a_built_sticks, built_ff, built_ff, "automaton lost its built state")
   `MPMC_ASSERT_NOW(a_pop_nonempty, state_ff == mpmc_pkg::S_B_POP, head_ff < tail_ff, "pop from empty BFS queue")
   `MPMC_ASSERT_NEXT(a_fin_clears, (state_ff == mpmc_pkg::S_FIN) && out_free, rsp_valid_ff && (total_ff == '0), "end of text did not post result and clear count")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the multi-pattern match counter.
module testbench;

   localparam int NODES       = mpmc_pkg::MAX_NODES_DEF;
   localparam int LETTERS     = mpmc_pkg::ALPHABET_DEF;
   localparam int ROOT        = 1;
   localparam int TOP_COUNT   = 65535;
   localparam int CYCLE_CAP   = 6000000;
   localparam int DICT_ITEMS  = 600;
   localparam int TOTAL_ITEMS = 1950;
   localparam int PHASE_ITEMS = 150;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mpmc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   mpmc_pkg::rsp_type rsp_data;

   multi_pattern_match_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Shadow copy of the automaton state.
   logic [11:0] trie_next [NODES*LETTERS];
   logic [11:0] fail_of   [NODES];
   logic [11:0] parent_of [NODES];
   logic [4:0]  letter_of [NODES];
   logic [15:0] ends_at   [NODES];
   bit          seen_node [NODES];
   logic [11:0] walk_list [NODES];
   int          last_node;
   int          cursor;
   int          found;
   bit          dropped;
   bit          automaton_ready;

   mpmc_pkg::rsp_type pending_counts[$];
   int                mismatches;
   int                cycles;
   int                accepted;
   int                idle_mode;

   // Short stored patterns, replayed as text so that matches actually happen.
   int pool_sym[$];
   int pool_start[$];
   int pool_len[$];

   typedef struct {
      mpmc_pkg::req_type r;
      bit                typed;
      mpmc_pkg::rsp_type want;
   } row_type;

   function automatic logic [15:0] count_up(input int a, input int b);
      return (a + b > TOP_COUNT) ? 16'(TOP_COUNT) : 16'(a + b);
   endfunction

   function automatic void grow_trie(input int sym);
      int slot;
      if (sym >= LETTERS) return;
      slot = cursor * LETTERS + sym;
      if (trie_next[slot] == 0) begin
         if (last_node + 1 >= NODES) begin
            dropped = 1'b1;
            return;
         end
         last_node++;
         trie_next[slot]      = 12'(last_node);
         parent_of[last_node] = 12'(cursor);
         letter_of[last_node] = 5'(sym);
      end
      cursor = int'(trie_next[slot]);
   endfunction

   // Breadth-first pass: failure links, then fill the holes from the failure row.
   function automatic void link_trie();
      int head;
      int tail;
      int k;
      int f;
      int child;
      head = 0;
      tail = 1;
      walk_list[0] = 12'(ROOT);
      while (head < tail) begin
         k = int'(walk_list[head]);
         head++;
         if (k == ROOT) fail_of[k] = '0;
         else fail_of[k] = trie_next[int'(fail_of[parent_of[k]]) * LETTERS + int'(letter_of[k])];
         f = int'(fail_of[k]);
         for (int i = 0; i < LETTERS; i++) begin
            child = int'(trie_next[k * LETTERS + i]);
            if (child != 0) begin
               if (tail < NODES) begin
                  walk_list[tail] = 12'(child);
                  tail++;
               end
            end else begin
               trie_next[k * LETTERS + i] = trie_next[f * LETTERS + i];
            end
         end
      end
      automaton_ready = 1'b1;
      cursor = ROOT;
   endfunction

   function automatic void scan_letter(input int sym);
      int u;
      cursor = (sym >= LETTERS) ? ROOT : int'(trie_next[cursor * LETTERS + sym]);
      u = cursor;
      while (u != 0 && !seen_node[u]) begin
         found = int'(count_up(found, int'(ends_at[u])));
         seen_node[u] = 1'b1;
         u = int'(fail_of[u]);
      end
   endfunction

   // Advance the shadow automaton by one transaction; return 1 when it emits a count.
   function automatic bit predict_counts(input mpmc_pkg::req_type r,
                                         output mpmc_pkg::rsp_type o);
      o = '0;
      case (r.opcode)
         mpmc_pkg::OP_PAT_LETTER: if (!automaton_ready) grow_trie(int'(r.symbol));
         mpmc_pkg::OP_PAT_END: begin
            if (!automaton_ready) begin
               ends_at[cursor] = count_up(int'(ends_at[cursor]), 1);
               cursor = ROOT;
            end
         end
         mpmc_pkg::OP_BUILD: if (!automaton_ready) link_trie();
         default: begin
            if (automaton_ready) scan_letter(int'(r.symbol));
            if (r.last_of_text) begin
               o.match_count = 16'(found);
               o.table_full  = dropped;
               found  = 0;
               cursor = ROOT;
               return 1'b1;
            end
         end
      endcase
      return 1'b0;
   endfunction

   function automatic bit sender_rests();
      case (idle_mode)
         1: return $urandom_range(99) < 56;
         3: return $urandom_range(99) < 29;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         2: return $urandom_range(99) < 56;
         3: return $urandom_range(99) < 29;
         default: return 1'b0;
      endcase
   endfunction

   function automatic int pick_letter();
      if ($urandom_range(99) < 70) return int'($urandom_range(7));
      return int'($urandom_range(LETTERS - 1));
   endfunction

   // Offer one transaction; starts and ends at a falling edge.
   task automatic send_item(input mpmc_pkg::req_type r, input bit typed,
                            input mpmc_pkg::rsp_type want);
      mpmc_pkg::rsp_type got;
      while (sender_rests()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      accepted++;
      idle_mode = (accepted / PHASE_ITEMS) % 4;
      if (predict_counts(r, got)) pending_counts.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic send(input mpmc_pkg::opcode_type op, input int sym, input bit last);
      mpmc_pkg::req_type r;
      r.opcode       = op;
      r.symbol       = 5'(sym);
      r.last_of_text = last;
      send_item(r, 1'b0, '0);
   endtask

   // Send one transaction that every state ignores or treats as a dictionary op.
   task automatic send_other();
      case ($urandom_range(2))
         0: send(mpmc_pkg::OP_PAT_LETTER, int'($urandom_range(31)), 1'($urandom_range(1)));
         1: send(mpmc_pkg::OP_PAT_END, int'($urandom_range(31)), 1'($urandom_range(1)));
         default: send(mpmc_pkg::OP_BUILD, int'($urandom_range(31)), 1'($urandom_range(1)));
      endcase
   endtask

   function automatic row_type mk(input mpmc_pkg::opcode_type op, input int sym,
                                  input bit last, input bit typed = 1'b0,
                                  input int cnt = 0, input bit full = 1'b0);
      row_type t;
      t.r.opcode         = op;
      t.r.symbol         = 5'(sym);
      t.r.last_of_text   = last;
      t.typed            = typed;
      t.want.match_count = 16'(cnt);
      t.want.table_full  = full;
      return t;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Drop run on runaway; count every cycle.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver side: stall at random according to the current idle mode.
   always @(negedge clock) begin
      rsp_ready <= !reset && !receiver_stalls();
   end

   // Compare every result transaction with the oldest expectation.
   always @(posedge clock) begin
      mpmc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: count %0d full %0d",
                        rsp_data.match_count, rsp_data.table_full);
         end else begin
            want = pending_counts.pop_front();
            if (want.match_count !== rsp_data.match_count ||
                want.table_full !== rsp_data.table_full) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected count %0d full %0d, got %0d %0d",
                           want.match_count, want.table_full,
                           rsp_data.match_count, rsp_data.table_full);
            end
         end
      end
   end

   initial begin
      row_type early_rows[$];
      row_type late_rows[$];
      int      word[$];
      int      text_syms[$];
      int      len;
      int      pick;
      int      segs;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      foreach (trie_next[i]) trie_next[i] = (i < LETTERS) ? 12'(ROOT) : '0;
      foreach (fail_of[i]) begin
         fail_of[i]   = '0;
         parent_of[i] = '0;
         letter_of[i] = '0;
         ends_at[i]   = '0;
         seen_node[i] = 1'b0;
      end
      last_node = ROOT;
      cursor    = ROOT;
      found     = 0;
      dropped   = 1'b0;
      automaton_ready = 1'b0;

      // Ahead of the build: text before build, out-of-range letter, duplicate
      // patterns, empty pattern, ignored last flags.
      early_rows = {
         mk(mpmc_pkg::OP_TEXT, 0, 1'b1, 1'b1, 0, 1'b0),
         mk(mpmc_pkg::OP_TEXT, 31, 1'b1, 1'b1, 0, 1'b0),
         mk(mpmc_pkg::OP_PAT_LETTER, 31, 1'b1),
         mk(mpmc_pkg::OP_PAT_LETTER, 0, 1'b0), mk(mpmc_pkg::OP_PAT_LETTER, 1, 1'b0),
         mk(mpmc_pkg::OP_PAT_END, 0, 1'b0),
         mk(mpmc_pkg::OP_PAT_LETTER, 0, 1'b0), mk(mpmc_pkg::OP_PAT_LETTER, 1, 1'b0),
         mk(mpmc_pkg::OP_PAT_END, 0, 1'b1),
         mk(mpmc_pkg::OP_PAT_LETTER, 25, 1'b0), mk(mpmc_pkg::OP_PAT_END, 31, 1'b0),
         mk(mpmc_pkg::OP_PAT_END, 0, 1'b0),
         mk(mpmc_pkg::OP_TEXT, 3, 1'b0),
         mk(mpmc_pkg::OP_TEXT, 4, 1'b1, 1'b1, 0, 1'b0)
      };
      // After the dictionary: build, matching text, out-of-range text,
      // repeated build, pattern input after build.
      late_rows = {
         mk(mpmc_pkg::OP_BUILD, 0, 1'b0),
         mk(mpmc_pkg::OP_TEXT, 0, 1'b0), mk(mpmc_pkg::OP_TEXT, 1, 1'b1),
         mk(mpmc_pkg::OP_TEXT, 31, 1'b1),
         mk(mpmc_pkg::OP_BUILD, 3, 1'b1),
         mk(mpmc_pkg::OP_PAT_LETTER, 2, 1'b0), mk(mpmc_pkg::OP_PAT_END, 0, 1'b0),
         mk(mpmc_pkg::OP_TEXT, 25, 1'b0), mk(mpmc_pkg::OP_TEXT, 0, 1'b0),
         mk(mpmc_pkg::OP_TEXT, 1, 1'b1),
         mk(mpmc_pkg::OP_TEXT, 30, 1'b0), mk(mpmc_pkg::OP_TEXT, 0, 1'b1)
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (early_rows[i]) send_item(early_rows[i].r, early_rows[i].typed, early_rows[i].want);

      // Random dictionary, with some text and empty patterns before the build.
      while (accepted < DICT_ITEMS) begin
         pick = int'($urandom_range(99));
         if (pick < 3) begin
            send(mpmc_pkg::OP_TEXT, int'($urandom_range(31)), 1'($urandom_range(1)));
         end else if (pick < 5) begin
            send(mpmc_pkg::OP_PAT_END, int'($urandom_range(31)), 1'($urandom_range(1)));
         end else begin
            word.delete();
            if (pool_len.size() > 0 && $urandom_range(99) < 5) begin
               pick = int'($urandom_range(pool_len.size() - 1));
               for (int j = 0; j < pool_len[pick]; j++)
                  word.push_back(pool_sym[pool_start[pick] + j]);
            end else begin
               if ($urandom_range(99) < 40) len = int'($urandom_range(1, 3));
               else len = int'($urandom_range(4, 14));
               repeat (len) word.push_back(pick_letter());
            end
            foreach (word[j]) begin
               if ($urandom_range(99) < 4)
                  send(mpmc_pkg::OP_PAT_LETTER, int'($urandom_range(26, 31)), 1'b0);
               send(mpmc_pkg::OP_PAT_LETTER, word[j], 1'($urandom_range(1)));
            end
            send(mpmc_pkg::OP_PAT_END, int'($urandom_range(31)), 1'($urandom_range(1)));
            if (word.size() <= 6 && pool_len.size() < 200) begin
               pool_start.push_back(pool_sym.size());
               pool_len.push_back(word.size());
               foreach (word[j]) pool_sym.push_back(word[j]);
            end
         end
      end

      foreach (late_rows[i]) send_item(late_rows[i].r, late_rows[i].typed, late_rows[i].want);

      // Random text built from stored patterns and loose letters.
      while (accepted < TOTAL_ITEMS) begin
         text_syms.delete();
         segs = int'($urandom_range(1, 4));
         repeat (segs) begin
            if (pool_len.size() > 0 && $urandom_range(99) < 50) begin
               pick = int'($urandom_range(pool_len.size() - 1));
               for (int j = 0; j < pool_len[pick]; j++)
                  text_syms.push_back(pool_sym[pool_start[pick] + j]);
            end else if ($urandom_range(99) < 5) begin
               text_syms.push_back(int'($urandom_range(26, 31)));
            end else begin
               text_syms.push_back(pick_letter());
            end
         end
         foreach (text_syms[j]) begin
            if ($urandom_range(99) < 3) send_other();
            send(mpmc_pkg::OP_TEXT, text_syms[j], j == text_syms.size() - 1);
         end
      end

      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/mpmc_pkg.sv
rtl/mpmc_goto_mem.sv
rtl/mpmc_node_mem.sv
rtl/multi_pattern_match_counter.sv
tb/testbench.sv
